// ----- hw/rtl/jdq_pkg.sv -----
// shared types and constants for the joystick direction qualifier
package jdq_pkg;

    // direction codes
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_LEFT  = 3'd1,
        DIR_RIGHT = 3'd2,
        DIR_UP    = 3'd3,
        DIR_DOWN  = 3'd4
    } jdq_dir_t;

    // register indexes on the configuration port
    localparam logic [1:0] REG_CENTER   = 2'd0;
    localparam logic [1:0] REG_DEADZONE = 2'd1;
    localparam logic [1:0] REG_COOLDOWN = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd3;

    // register reset values
    localparam logic [11:0] CENTER_RESET   = 12'd2048;
    localparam logic [11:0] DEADZONE_RESET = 12'd600;
    localparam logic [15:0] COOLDOWN_RESET = 16'd250;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd25;

    // queue between classifier and state update
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // configuration seen by both halves
    typedef struct packed {
        logic [11:0] center_value;
        logic [11:0] deadzone;
        logic [15:0] cooldown_ms;
        logic [15:0] debounce_ms;
    } jdq_cfg_t;

    // classified poll handed from front to back
    typedef struct packed {
        jdq_dir_t    dir;
        logic        switch_level;
        logic [31:0] time_ms;
    } jdq_item_t;

    // one result
    typedef struct packed {
        logic     press_event;
        jdq_dir_t direction_event;
        jdq_dir_t direction_now;
    } jdq_result_t;

    // running state of the back end, for checking
    typedef struct packed {
        jdq_dir_t held_dir;
        logic     debounced;
    } jdq_status_t;

endpackage

// ----- hw/rtl/joystick_direction_qualifier.sv -----
// top level: joystick direction qualifier with switch debounce
// Takes one poll (X and Y samples, raw switch level, millisecond timestamp) per
// transfer and returns exactly one result per poll: the current direction, a
// direction event code when a new direction passes the cooldown, and a press
// flag when the debounced switch goes low. A poll can be taken every clock
// cycle while the result output is not stalled. The input stage loads at the
// transfer, then the two-entry queue, then the result register, which offers
// the result. The sustained rate of one poll per cycle while unstalled is set
// by the back end, which updates the held direction and debounce state once
// per poll. Write the registers only while no poll is in flight. Register map:
// 0x0 center_value, 0x4 deadzone, 0x8 cooldown_ms, 0xC debounce_ms.
module joystick_direction_qualifier #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    // poll input
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_sample, y_sample, switch_level, time_ms, zero fill
    input  logic [(((2 * SAMPLE_BITS + 33) + 7) / 8) * 8 - 1:0] s_tdata,
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // direction_now[2:0], direction_event[5:3], press_event[6], zero fill[7]
    output logic [7:0]  m_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW_POS   = 2 * SAMPLE_BITS;
    localparam int TIME_LSB = 2 * SAMPLE_BITS + 1;

    jdq_pkg::jdq_cfg_t     cfg_reg;
    logic                  cfg_write;
    logic                  front_valid;
    logic                  front_ready;
    jdq_pkg::jdq_item_t    front_item;
    logic                  queue_valid;
    logic                  queue_ready;
    jdq_pkg::jdq_item_t    queue_item;
    jdq_pkg::jdq_result_t  result;
    jdq_pkg::jdq_status_t  status;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.center_value <= jdq_pkg::CENTER_RESET;
            cfg_reg.deadzone     <= jdq_pkg::DEADZONE_RESET;
            cfg_reg.cooldown_ms  <= jdq_pkg::COOLDOWN_RESET;
            cfg_reg.debounce_ms  <= jdq_pkg::DEBOUNCE_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                jdq_pkg::REG_CENTER:   cfg_reg.center_value <= pwdata[11:0];
                jdq_pkg::REG_DEADZONE: cfg_reg.deadzone     <= pwdata[11:0];
                jdq_pkg::REG_COOLDOWN: cfg_reg.cooldown_ms  <= pwdata[15:0];
                jdq_pkg::REG_DEBOUNCE: cfg_reg.debounce_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[3:2])
            jdq_pkg::REG_CENTER:   prdata = 32'(cfg_reg.center_value);
            jdq_pkg::REG_DEADZONE: prdata = 32'(cfg_reg.deadzone);
            jdq_pkg::REG_COOLDOWN: prdata = 32'(cfg_reg.cooldown_ms);
            jdq_pkg::REG_DEBOUNCE: prdata = 32'(cfg_reg.debounce_ms);
            default:               prdata = '0;
        endcase
    end

    // classifier
    jdq_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .x_sample     (s_tdata[SAMPLE_BITS-1:0]),
        .y_sample     (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .switch_level (s_tdata[SW_POS]),
        .time_ms      (s_tdata[TIME_LSB+31:TIME_LSB]),
        .out_valid    (front_valid),
        .out_ready    (front_ready),
        .out_item     (front_item)
    );

    // decoupling queue
    jdq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_item  (queue_item)
    );

    // state update and result register
    jdq_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (queue_valid),
        .in_ready   (queue_ready),
        .in_item    (queue_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .status     (status)
    );

    assign m_tdata = {1'b0, result};

    // an event always names the current direction
    a_event_is_now: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.direction_event != jdq_pkg::DIR_NONE) |->
        (result.direction_event == result.direction_now))
        else $error("direction event differs from current direction");

    // a pending event is the held direction
    a_event_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.direction_event != jdq_pkg::DIR_NONE) |->
        (status.held_dir == result.direction_event))
        else $error("held direction does not match pending event");

    // a pending press leaves the debounced level low
    a_press_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.press_event) |-> !status.debounced)
        else $error("press event with released debounced level");

endmodule

// ----- hw/rtl/jdq_front.sv -----
// front end: takes polls and classifies the stick direction
module jdq_front #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  jdq_pkg::jdq_cfg_t          cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [SAMPLE_BITS-1:0]     x_sample,
    input  logic [SAMPLE_BITS-1:0]     y_sample,
    input  logic                       switch_level,
    input  logic [31:0]                time_ms,
    output logic                       out_valid,
    input  logic                       out_ready,
    output jdq_pkg::jdq_item_t         out_item
);

    localparam int DW = ((SAMPLE_BITS > 12) ? SAMPLE_BITS : 12) + 1;

    logic [DW-1:0]       dx;
    logic [DW-1:0]       dy;
    logic [DW-1:0]       ax;
    logic [DW-1:0]       ay;
    logic [DW-1:0]       dz;
    jdq_pkg::jdq_dir_t   dir;
    logic                valid_reg;
    logic                valid_next;
    jdq_pkg::jdq_item_t  item_reg;
    logic                load;

    // signed offsets from center and their magnitudes
    always_comb begin
        dx = DW'(x_sample) - DW'(cfg.center_value);
        dy = DW'(y_sample) - DW'(cfg.center_value);
        ax = dx[DW-1] ? (~dx + DW'(1)) : dx;
        ay = dy[DW-1] ? (~dy + DW'(1)) : dy;
        dz = DW'(cfg.deadzone);
    end

    // deadzone test, then dominant axis with x winning ties
    always_comb begin
        if (ax < dz && ay < dz) begin
            dir = jdq_pkg::DIR_NONE;
        end else if (ax >= ay) begin
            dir = dx[DW-1] ? jdq_pkg::DIR_LEFT : jdq_pkg::DIR_RIGHT;
        end else begin
            dir = dy[DW-1] ? jdq_pkg::DIR_UP : jdq_pkg::DIR_DOWN;
        end
    end

    // one-entry stage in front of the queue
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.dir          <= dir;
            item_reg.switch_level <= switch_level;
            item_reg.time_ms      <= time_ms;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ----- hw/rtl/jdq_queue.sv -----
// short queue of classified polls between front and back end
module jdq_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  jdq_pkg::jdq_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output jdq_pkg::jdq_item_t  out_item
);

    jdq_pkg::jdq_item_t               entry_reg [jdq_pkg::QUEUE_DEPTH];
    logic [jdq_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [jdq_pkg::QPTR_W-1:0]       wr_ptr_next;
    logic [jdq_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [jdq_pkg::QPTR_W-1:0]       rd_ptr_next;
    logic [jdq_pkg::QCNT_W-1:0]       count_reg;
    logic [jdq_pkg::QCNT_W-1:0]       count_next;
    logic                             push;
    logic                             pop;

    assign in_ready  = (count_reg != jdq_pkg::QCNT_W'(jdq_pkg::QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == jdq_pkg::QPTR_W'(jdq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == jdq_pkg::QPTR_W'(jdq_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/jdq_back.sv -----
// back end: direction events with cooldown, switch debounce, result register
module jdq_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  jdq_pkg::jdq_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  jdq_pkg::jdq_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jdq_pkg::jdq_result_t out_result,
    output jdq_pkg::jdq_status_t status
);

    jdq_pkg::jdq_dir_t     held_dir_reg;
    jdq_pkg::jdq_dir_t     held_dir_next;
    logic [31:0]           last_event_time_reg;
    logic [31:0]           last_event_time_next;
    logic                  debounced_reg;
    logic                  debounced_next;
    logic                  sw_prev_raw_reg;
    logic                  sw_prev_raw_next;
    logic [31:0]           sw_change_time_reg;
    logic [31:0]           sw_change_time_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    jdq_pkg::jdq_result_t  result_reg;
    jdq_pkg::jdq_result_t  result_next;
    logic                  press_next;
    logic                  take;
    logic [31:0]           since_event;
    logic [31:0]           since_change;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // direction event with cooldown
    always_comb begin
        held_dir_next        = held_dir_reg;
        last_event_time_next = last_event_time_reg;
        result_next.direction_now   = in_item.dir;
        result_next.direction_event = jdq_pkg::DIR_NONE;
        result_next.press_event     = press_next;
        since_event = in_item.time_ms - last_event_time_reg;
        if (in_item.dir == jdq_pkg::DIR_NONE) begin
            held_dir_next = jdq_pkg::DIR_NONE;
        end else if (in_item.dir != held_dir_reg &&
                     since_event >= 32'(cfg.cooldown_ms)) begin
            held_dir_next               = in_item.dir;
            last_event_time_next        = in_item.time_ms;
            result_next.direction_event = in_item.dir;
        end
    end

    // switch debounce and press detect
    always_comb begin
        sw_prev_raw_next    = sw_prev_raw_reg;
        sw_change_time_next = sw_change_time_reg;
        debounced_next      = debounced_reg;
        press_next          = 1'b0;
        if (in_item.switch_level != sw_prev_raw_reg) begin
            sw_prev_raw_next    = in_item.switch_level;
            sw_change_time_next = in_item.time_ms;
        end
        since_change = in_item.time_ms - sw_change_time_next;
        if (since_change >= 32'(cfg.debounce_ms) &&
            in_item.switch_level != debounced_reg) begin
            debounced_next = in_item.switch_level;
            press_next     = !in_item.switch_level;
        end
    end

    // result register valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_dir_reg        <= jdq_pkg::DIR_NONE;
            last_event_time_reg <= '0;
            debounced_reg       <= 1'b1;
            sw_prev_raw_reg     <= 1'b1;
            sw_change_time_reg  <= '0;
            out_valid_reg       <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                held_dir_reg        <= held_dir_next;
                last_event_time_reg <= last_event_time_next;
                debounced_reg       <= debounced_next;
                sw_prev_raw_reg     <= sw_prev_raw_next;
                sw_change_time_reg  <= sw_change_time_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;
    assign status     = {held_dir_reg, debounced_reg};

endmodule
